FILE: hdl/sli_pkg.sv
package sli_pkg;

  localparam int DATA_W = 32;
  localparam int POS_W  = 6;
  localparam int LEN_W  = 6;
  localparam int OP_W   = 2;

  // request codes on in_operation
  localparam logic [OP_W-1:0] OP_GET    = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
  // code with no meaning, always answered as an error
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // action broadcast along the cell row
  localparam logic [1:0] ACT_HOLD   = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef struct packed {
    logic [1:0]               act;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

FILE: hdl/sli_cell.sv
module sli_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  sli_pkg::cell_cmd_t                cmd,
  input  logic signed [sli_pkg::DATA_W-1:0] left_value,
  input  logic signed [sli_pkg::DATA_W-1:0] right_value,
  output logic signed [sli_pkg::DATA_W-1:0] value,
  output logic                              hit
);
  import sli_pkg::*;

  // 1-based list position held by this cell
  localparam logic [31:0] MY_POS = 32'(IDX + 1);

  logic [31:0]              pos_w;
  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  assign pos_w = {{(32-POS_W){1'b0}}, cmd.pos};
  assign hit   = (pos_w == MY_POS);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    unique case (cmd.act)
      ACT_HOLD: begin
        value_nxt = value_r;
      end
      ACT_INSERT: begin
        if (pos_w == MY_POS) begin
          value_nxt = cmd.value;
        end else if (pos_w < MY_POS) begin
          value_nxt = left_value;
        end
      end
      ACT_DELETE: begin
        if (pos_w <= MY_POS) begin
          value_nxt = right_value;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

FILE: hdl/sequential_list_insert_delete.sv
// bounded ordered list of signed 32-bit elements, one element per cell
// input channel: in_operation (get / insert / delete), in_position (1-based),
//   in_new_value; an item is taken when in_valid is high and in_stall low
// result channel: out_status (0 ok, 1 error), out_element, out_list_length;
//   exactly one result per item, taken when out_valid is high and out_stall low
// result: registered, it shows on the outputs in the cycle after the item is taken
// throughput: one item per cycle unless a result waits under out_stall; every
//   cell loads its neighbor's value in the same cycle, so an insert or delete
//   shift finishes in the accept cycle and the next item may follow at once
// the single output register gates the rate: while a result waits under
//   out_stall, in_stall is raised and no new item is taken; a taken result
//   frees the register in the same cycle for the next item
// reset (rst_n low, synchronous): the list becomes empty and the output
//   register empties; in_stall stays high while reset is held
// element values are kept without reset, positions past the length are
//   never read
module sequential_list_insert_delete #(
  parameter int CAPACITY = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [sli_pkg::OP_W-1:0]          in_operation,
  input  logic [sli_pkg::POS_W-1:0]         in_position,
  input  logic signed [sli_pkg::DATA_W-1:0] in_new_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_status,
  output logic signed [sli_pkg::DATA_W-1:0] out_element,
  output logic [sli_pkg::LEN_W-1:0]         out_list_length
);
  import sli_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width wide enough for both the position and length+1
  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  // list length
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // output register
  logic                     out_valid_r;
  logic                     out_status_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic [LEN_W-1:0]         out_list_length_r;

  logic                     in_accept;
  logic                     out_free;
  logic [CMP_W-1:0]         pos_c;
  logic [CMP_W-1:0]         cnt_c;
  logic                     pos_in_list;
  logic                     pos_in_list_ext;
  logic                     full;
  logic                     req_ok;
  logic                     req_read;
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] rd_value;
  logic signed [DATA_W-1:0] cell_value [CAPACITY];
  logic                     cell_hit   [CAPACITY];

  // handshake: a new item goes in when the output register is empty or drains
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !rst_n || !out_free;
  assign in_accept = in_valid && !in_stall;

  // range checks; position 0 is never valid
  assign pos_c           = CMP_W'(in_position);
  assign cnt_c           = CMP_W'(count_r);
  assign full            = (count_r == CNT_W'(CAPACITY));
  assign pos_in_list     = (in_position != '0) && (pos_c <= cnt_c);
  assign pos_in_list_ext = (in_position != '0) && (pos_c <= cnt_c + CMP_W'(1));

  // request decode
  always_comb begin
    req_ok    = 1'b0;
    req_read  = 1'b0;
    cmd.act   = ACT_HOLD;
    cmd.pos   = in_position;
    cmd.value = in_new_value;
    count_nxt = count_r;
    unique case (in_operation)
      OP_GET: begin
        req_ok   = pos_in_list;
        req_read = 1'b1;
      end
      OP_INSERT: begin
        req_ok = !full && pos_in_list_ext;
        if (in_accept && req_ok) begin
          cmd.act   = ACT_INSERT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        req_ok   = pos_in_list;
        req_read = 1'b1;
        if (in_accept && req_ok) begin
          cmd.act   = ACT_DELETE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: begin
        // unused code answers as an error
        req_ok = 1'b0;
      end
    endcase
  end

  // row of cells, each shifting from its left or right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_v;
    logic signed [DATA_W-1:0] right_v;

    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_value[i+1];
    end

    sli_cell #(
      .IDX (i)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (cell_value[i]),
      .hit         (cell_hit[i])
    );
  end

  // the cell at the requested position drives the read value
  always_comb begin
    rd_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_hit[i]) begin
        rd_value = rd_value | cell_value[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded with the item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_status_r      <= req_ok ? STATUS_OK : STATUS_ERR;
      out_element_r     <= (req_ok && req_read) ? rd_value : '0;
      out_list_length_r <= LEN_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_element     = out_element_r;
  assign out_list_length = out_list_length_r;

endmodule

FILE: hdl/sli_checker.sv
module sli_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [sli_pkg::OP_W-1:0]          in_operation,
  input logic [sli_pkg::POS_W-1:0]         in_position,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_status,
  input logic signed [sli_pkg::DATA_W-1:0] out_element,
  input logic [sli_pkg::LEN_W-1:0]         out_list_length
);
  import sli_pkg::*;

  logic in_take;

  assign in_take = rst_n && in_valid && !in_stall;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_list_length))
    else $error("stalled result changed");

  // every taken item yields a result in the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid)
    else $error("taken item gave no result");

  // error results carry a zero element
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_ERR) |-> out_element == '0)
    else $error("error result with nonzero element");

  // position zero or an unused code is always refused
  a_bad_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && ((in_position == '0) || (in_operation == OP_UNUSED))
      |=> out_status == STATUS_ERR)
    else $error("bad request not refused");

endmodule

bind sequential_list_insert_delete sli_checker u_sli_checker (.*);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sli_pkg::*;

  // list size of the instance under test
  localparam int CAPACITY = 32;
  localparam int RANDOM_ITEMS = 620;
  // worst case is roughly 700 items, each after a long gap and a long stall
  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 8;

  // one result item as the block reports it
  typedef struct packed {
    logic                     status;
    logic signed [DATA_W-1:0] element;
    logic [LEN_W-1:0]         length;
  } list_answer_t;

  // one row of the directed plan; typed rows carry their answer, the rest use
  // the list predictor; rows with repeats add the repeat index to the value
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
    int                       repeats;
    bit                       typed;
    list_answer_t             answer;
  } plan_row_t;

  localparam int PLAN_ROWS = 25;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OP_W-1:0] in_operation = '0;
  logic [POS_W-1:0] in_position = '0;
  logic signed [DATA_W-1:0] in_new_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic signed [DATA_W-1:0] out_element;
  logic [LEN_W-1:0] out_list_length;

  // shadow copy of the list
  logic signed [DATA_W-1:0] list_cells [0:CAPACITY-1];
  int list_count = 0;

  // answers still owed by the block, oldest first
  list_answer_t answers_owed [$];

  int mismatches = 0;
  int cycle_count = 0;
  int answers_checked = 0;
  int directed_sent = 0;
  int random_sent = 0;
  int gets_ok = 0;
  int inserts_ok = 0;
  int deletes_ok = 0;
  int rejected = 0;
  int times_full = 0;
  int calm_items = 0;
  bit growing = 1'b1;

  // directed plan: empty list errors, extremes of value and position, every
  // operation, insert at front, middle and end, then fill to full, poke the
  // full list, and drain it back to empty
  plan_row_t directed_plan [0:PLAN_ROWS-1] = '{
    // empty list: get and delete fail
    '{OP_GET,     6'd1,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}},
    '{OP_DELETE,  6'd1,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}},
    // insert at position zero and past the end
    '{OP_INSERT,  6'd0,  32'h11,       1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}},
    '{OP_INSERT,  6'd2,  32'h11,       1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}},
    '{OP_UNUSED,  6'd1,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}},
    // build [80000000, 5a5a5a5a, 7fffffff, ffffffff]
    '{OP_INSERT,  6'd1,  32'h7fffffff, 1,  1'b1, '{STATUS_OK,  32'h0, 6'd1}},
    '{OP_INSERT,  6'd1,  32'h80000000, 1,  1'b1, '{STATUS_OK,  32'h0, 6'd2}},
    '{OP_INSERT,  6'd3,  32'hffffffff, 1,  1'b1, '{STATUS_OK,  32'h0, 6'd3}},
    '{OP_INSERT,  6'd2,  32'h5a5a5a5a, 1,  1'b1, '{STATUS_OK,  32'h0, 6'd4}},
    '{OP_GET,     6'd1,  32'h0,        1,  1'b1, '{STATUS_OK,  32'h80000000, 6'd4}},
    // value is ignored by get, all ones here
    '{OP_GET,     6'd4,  32'hffffffff, 1,  1'b1, '{STATUS_OK,  32'hffffffff, 6'd4}},
    '{OP_GET,     6'd5,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd4}},
    '{OP_GET,     6'd63, 32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd4}},
    '{OP_DELETE,  6'd0,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd4}},
    '{OP_DELETE,  6'd2,  32'h0,        1,  1'b1, '{STATUS_OK,  32'h5a5a5a5a, 6'd3}},
    '{OP_DELETE,  6'd3,  32'h0,        1,  1'b1, '{STATUS_OK,  32'hffffffff, 6'd2}},
    '{OP_UNUSED,  6'd2,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd2}},
    // fill up to capacity, always in the middle
    '{OP_INSERT,  6'd2,  32'h00010000, 30, 1'b0, '0},
    // full list refuses both append and front insert
    '{OP_INSERT,  6'd33, 32'h1,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd32}},
    '{OP_INSERT,  6'd1,  32'h1,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd32}},
    '{OP_GET,     6'd32, 32'h0,        1,  1'b0, '0},
    '{OP_GET,     6'd33, 32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd32}},
    '{OP_DELETE,  6'd32, 32'h0,        1,  1'b0, '0},
    // drain from the front down to empty
    '{OP_DELETE,  6'd1,  32'h0,        31, 1'b0, '0},
    '{OP_GET,     6'd1,  32'h0,        1,  1'b1, '{STATUS_ERR, 32'h0, 6'd0}}
  };

  sequential_list_insert_delete #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_operation(in_operation),
    .in_position(in_position),
    .in_new_value(in_new_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_element(out_element),
    .out_list_length(out_list_length)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // run limit, counted in clock cycles
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers still owed", cycle_count,
               answers_owed.size());
      $display("[sequential_list_insert_delete] ERROR");
      $finish;
    end
  end

  // applies one request to the shadow list and returns what the block owes
  function automatic list_answer_t apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                                 logic signed [DATA_W-1:0] value);
    list_answer_t answer;
    int p;
    p = pos;
    answer.status = STATUS_ERR;
    answer.element = '0;
    case (op)
      OP_GET: begin
        if (p >= 1 && p <= list_count) begin
          answer.status = STATUS_OK;
          answer.element = list_cells[p-1];
          gets_ok++;
        end
      end
      OP_INSERT: begin
        if (list_count >= CAPACITY) times_full++;
        if (list_count < CAPACITY && p >= 1 && p <= list_count + 1) begin
          // open a hole at p by shifting the tail up
          for (int k = list_count; k >= p; k--) list_cells[k] = list_cells[k-1];
          list_cells[p-1] = value;
          list_count++;
          answer.status = STATUS_OK;
          inserts_ok++;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= list_count) begin
          answer.element = list_cells[p-1];
          // close the hole by shifting the tail down
          for (int k = p; k < list_count; k++) list_cells[k-1] = list_cells[k];
          list_count--;
          answer.status = STATUS_OK;
          deletes_ok++;
        end
      end
      default: ;
    endcase
    if (answer.status == STATUS_ERR) rejected++;
    answer.length = LEN_W'(list_count);
    return answer;
  endfunction

  // idle gap before an item: mostly none or short, now and then long, and
  // runs of back to back items
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_items > 0) begin
      calm_items--;
      return 0;
    end
    if (roll < 8) begin
      calm_items = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 10);
    return $urandom_range(15, 30);
  endfunction

  // position that usually hits the ends or the inside of 1..top
  function automatic logic [POS_W-1:0] pick_position(int top);
    int roll;
    roll = $urandom_range(0, 9);
    if (top == 0 || roll == 0) return POS_W'($urandom_range(0, 63));
    if (roll < 3) return POS_W'(1);
    if (roll < 5) return POS_W'(top);
    return POS_W'($urandom_range(1, top));
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h0;
      3: return 32'hffffffff;
      default: return $urandom;
    endcase
  endfunction

  // drives one item, holds it until taken, and books its answer
  task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                              input logic signed [DATA_W-1:0] value, input bit typed,
                              input list_answer_t typed_answer);
    list_answer_t predicted;
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_position <= pos;
    in_new_value <= value;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(op, pos, value);
    answers_owed.push_back(typed ? typed_answer : predicted);
  endtask

  // random request: the list swings between empty and full, gets sprinkled
  // in, and a few items are plain noise on every field
  task automatic random_request();
    int roll;
    int choice;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    if (list_count >= CAPACITY) growing = 1'b0;
    else if (list_count == 0) growing = 1'b1;
    roll = $urandom_range(0, 99);
    choice = $urandom_range(0, 9);
    if (roll < 5) begin
      op = OP_W'($urandom_range(0, 3));
      pos = POS_W'($urandom_range(0, 63));
    end else if (roll < 30) begin
      op = OP_GET;
      pos = pick_position(list_count);
    end else if (growing ? choice < 7 : choice < 3) begin
      op = OP_INSERT;
      pos = pick_position(list_count + 1);
    end else begin
      op = OP_DELETE;
      pos = pick_position(list_count);
    end
    send_request(op, pos, pick_value(), 1'b0, '0);
  endtask

  // result side: random stall bursts, short and long, with calm stretches
  initial begin : result_backpressure
    int calm_left;
    int stall_left;
    int roll;
    calm_left = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 10) calm_left = $urandom_range(20, 80);
        else if (roll < 16) stall_left = $urandom_range(8, 40);
        else if (roll < 50) stall_left = $urandom_range(1, 3);
        else calm_left = $urandom_range(1, 6);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker: every taken result against the oldest owed answer
  always @(posedge clk) begin : answer_check
    list_answer_t owed;
    if (rst_n && out_valid && !out_stall) begin
      if (answers_owed.size() == 0) begin
        $display("%0t unexpected result: status %0d element %h length %0d", $time,
                 out_status, out_element, out_list_length);
        mismatches++;
      end else begin
        owed = answers_owed.pop_front();
        answers_checked++;
        if (out_status !== owed.status) begin
          $display("%0t status mismatch: expected %0d, got %0d", $time, owed.status,
                   out_status);
          mismatches++;
        end
        if (out_element !== owed.element) begin
          $display("%0t element mismatch: expected %h, got %h", $time, owed.element,
                   out_element);
          mismatches++;
        end
        if (out_list_length !== owed.length) begin
          $display("%0t length mismatch: expected %0d, got %0d", $time, owed.length,
                   out_list_length);
          mismatches++;
        end
      end
    end
  end

  // main sequence: reset, directed plan, random traffic, drain, verdict
  initial begin : main_sequence
    plan_row_t row;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < PLAN_ROWS; i++) begin
      row = directed_plan[i];
      for (int k = 0; k < row.repeats; k++) begin
        send_request(row.op, row.pos, row.value + DATA_W'(k), row.typed, row.answer);
        directed_sent++;
      end
    end

    repeat (RANDOM_ITEMS) begin
      random_request();
      random_sent++;
    end

    in_valid <= 1'b0;
    while (answers_owed.size() != 0) @(posedge clk);
    // keep waiting to catch any stray result
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d directed and %0d random requests, checked %0d results",
             directed_sent, random_sent, answers_checked);
    $display("accepted: %0d gets, %0d inserts, %0d deletes; %0d refused, %0d on a full list",
             gets_ok, inserts_ok, deletes_ok, rejected, times_full);
    if (mismatches == 0 && answers_owed.size() == 0) begin
      $display("[sequential_list_insert_delete] OK");
    end else begin
      $display("[sequential_list_insert_delete] ERROR");
    end
    $finish;
  end

endmodule
